### design/assert_macros.svh
// assertion macros used by the checker module
// needs a clock and an active-low reset name at each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is active
`define WFC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is active
`define WFC_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/wfc_pkg.sv
// word frequency counter: shared constants, result layout
// no dependencies
`default_nettype none

package wfc_pkg;

  localparam int DefMaxWords   = 128;
  localparam int DefMaxWordLen = 32;

  localparam int ByteW      = 8;
  localparam int CountW     = 8;
  localparam int SlotFieldW = 7;
  localparam int LenFieldW  = 6;

  localparam int InDataW  = 8;
  localparam int OutDataW = 24;

  localparam logic [ByteW-1:0]  NewlineByte = 8'd10;
  localparam logic [ByteW-1:0]  DelimReset  = 8'd32;
  localparam logic [CountW-1:0] CountMax    = 8'd255;

  // result word as it sits in the master tdata, lowest bit last in the list
  typedef struct packed {
    logic [LenFieldW-1:0]  word_length;
    logic                  was_truncated;
    logic                  table_full;
    logic                  is_new_word;
    logic [CountW-1:0]     occurrence_count;
    logic [SlotFieldW-1:0] slot_index;
  } wfc_result_t;

endpackage

`default_nettype wire

### design/wfc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module wfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/word_frequency_counter_unit.sv
// word frequency counter top level: tokenizer, table search, insert, result register
// depends on wfc_pkg and wfc_ram
`default_nettype none

// Usage
//   slave stream: s_axis_tdata = char_byte [7:0], s_axis_tlast = end_of_sentence.
//   master stream: one word per closed non-empty word, fields in tdata as in
//   wfc_result_t, m_axis_tlast = sentence_done.
//   cfg_we_i / cfg_wdata_i write the delimiter byte (reset 32), only while idle.
// Operation
//   a byte that closes no word leaves the unit idle; the next byte is taken the cycle after.
//   a closing byte runs a search over the table words in order of first appearance:
//   each entry's stored length is read first, and an entry of equal length is compared
//   byte by byte; a word not found is copied into the table if it has room, and
//   the result is then handed to the output register. The table memories have
//   one read port each, so entries and bytes are read one at a time.
// Reset clears the table fill count and the pending word; memories are not swept.
// The output register holds a result while the receiver stalls; bytes keep being
// taken until a second result would be needed, then tready drops.
module word_frequency_counter_unit
  import wfc_pkg::*;
#(
  parameter int MAX_WORDS    = DefMaxWords,
  parameter int MAX_WORD_LEN = DefMaxWordLen
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [ByteW-1:0]    cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // [7:0] char_byte
  input  wire logic                s_axis_tlast,  // end_of_sentence
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [6:0] slot_index, [14:7] occurrence_count, [15] is_new_word,
  // [16] table_full, [17] was_truncated, [23:18] word_length
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast   // sentence_done
);

  localparam int SlotW  = $clog2(MAX_WORDS);
  localparam int UsedW  = $clog2(MAX_WORDS + 1);
  localparam int LenW   = $clog2(MAX_WORD_LEN + 1);
  localparam int PendAW = $clog2(MAX_WORD_LEN);
  localparam int TxtAW  = $clog2(MAX_WORDS * MAX_WORD_LEN);
  localparam int MetaW  = LenW + CountW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_META = 6'b000010,
    S_MCHK = 6'b000100,
    S_CMP  = 6'b001000,
    S_COPY = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [ByteW-1:0]  delim_q;
  logic [UsedW-1:0]  used_q, used_d;
  logic [LenW-1:0]   plen_q, plen_d, plen_n;
  logic              trunc_q, trunc_d, trunc_n;
  logic              last_q, last_d;
  logic [UsedW-1:0]  slot_q, slot_d;
  logic [TxtAW-1:0]  base_q, base_d;
  logic [LenW-1:0]   idx_q, idx_d;
  logic [LenW-1:0]   wr_idx_q, wr_idx_d;
  logic              rd_pend_q, rd_pend_d;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_inc;
  wfc_result_t       res_q, res_d;
  logic              out_valid_q, out_valid_d;
  wfc_result_t       out_q, out_d;
  logic              out_last_q, out_last_d;

  logic              in_acc, is_delim;
  logic [ByteW-1:0]  in_byte;

  logic              pend_we;
  logic [ByteW-1:0]  pend_rdata;
  logic              txt_we;
  logic [TxtAW-1:0]  txt_waddr, txt_raddr;
  logic [ByteW-1:0]  txt_rdata;
  logic              meta_we;
  logic [MetaW-1:0]  meta_wdata, meta_rdata;
  logic [LenW-1:0]   meta_len;

  assign in_byte       = s_axis_tdata[ByteW-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_delim      = (in_byte == delim_q) || (in_byte == NewlineByte);

  assign txt_raddr = base_q + TxtAW'(idx_q);
  assign txt_waddr = base_q + TxtAW'(wr_idx_q);
  assign meta_len  = meta_rdata[MetaW-1 -: LenW];
  assign cnt_inc   = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;

  wfc_ram #(.Width(ByteW), .Depth(MAX_WORD_LEN)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (plen_q[PendAW-1:0]),
    .wdata_i (in_byte),
    .raddr_i (idx_q[PendAW-1:0]),
    .rdata_o (pend_rdata)
  );

  wfc_ram #(.Width(ByteW), .Depth(MAX_WORDS * MAX_WORD_LEN)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (txt_waddr),
    .wdata_i (pend_rdata),
    .raddr_i (txt_raddr),
    .rdata_o (txt_rdata)
  );

  // per entry: stored length and occurrence count
  wfc_ram #(.Width(MetaW), .Depth(MAX_WORDS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (slot_q[SlotW-1:0]),
    .wdata_i (meta_wdata),
    .raddr_i (slot_q[SlotW-1:0]),
    .rdata_o (meta_rdata)
  );

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    plen_d      = plen_q;
    trunc_d     = trunc_q;
    last_d      = last_q;
    slot_d      = slot_q;
    base_d      = base_q;
    idx_d       = idx_q;
    wr_idx_d    = wr_idx_q;
    rd_pend_d   = rd_pend_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    out_last_d  = out_last_q;
    plen_n      = plen_q;
    trunc_n     = trunc_q;
    pend_we     = 1'b0;
    txt_we      = 1'b0;
    meta_we     = 1'b0;
    meta_wdata  = {plen_q, cnt_inc};

    res_d.was_truncated = trunc_q;
    res_d.word_length   = LenFieldW'(plen_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!is_delim) begin
            if (plen_q < LenW'(MAX_WORD_LEN)) begin
              pend_we = 1'b1;
              plen_n  = plen_q + 1'b1;
            end else begin
              trunc_n = 1'b1;
            end
          end
          if ((is_delim || s_axis_tlast) && (plen_n != '0)) begin
            plen_d  = plen_n;
            trunc_d = trunc_n;
            last_d  = s_axis_tlast;
            slot_d  = '0;
            base_d  = '0;
            state_d = S_META;
          end else if (s_axis_tlast) begin
            used_d  = '0;
            plen_d  = '0;
            trunc_d = 1'b0;
          end else begin
            plen_d  = plen_n;
            trunc_d = trunc_n;
          end
        end
      end
      S_META: begin
        idx_d     = '0;
        wr_idx_d  = '0;
        rd_pend_d = 1'b0;
        if (slot_q == used_q) begin
          if (used_q == UsedW'(MAX_WORDS)) begin
            res_d.slot_index       = '0;
            res_d.occurrence_count = '0;
            res_d.is_new_word      = 1'b0;
            res_d.table_full       = 1'b1;
            state_d                = S_OUT;
          end else begin
            state_d = S_COPY;
          end
        end else begin
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        cnt_d = meta_rdata[CountW-1:0];
        if (meta_len == plen_q) begin
          state_d = S_CMP;
        end else begin
          slot_d  = slot_q + 1'b1;
          base_d  = base_q + TxtAW'(MAX_WORD_LEN);
          state_d = S_META;
        end
      end
      S_CMP: begin
        // read data belongs to the index issued in the previous cycle
        if (rd_pend_q && (txt_rdata != pend_rdata)) begin
          slot_d  = slot_q + 1'b1;
          base_d  = base_q + TxtAW'(MAX_WORD_LEN);
          state_d = S_META;
        end else if (idx_q == plen_q) begin
          meta_we                = 1'b1;
          res_d.slot_index       = SlotFieldW'(slot_q);
          res_d.occurrence_count = cnt_inc;
          res_d.is_new_word      = 1'b0;
          res_d.table_full       = 1'b0;
          state_d                = S_OUT;
        end else begin
          idx_d     = idx_q + 1'b1;
          rd_pend_d = 1'b1;
        end
      end
      S_COPY: begin
        txt_we = rd_pend_q;
        if (idx_q == plen_q) begin
          meta_we                = 1'b1;
          meta_wdata             = {plen_q, CountW'(1)};
          used_d                 = used_q + 1'b1;
          res_d.slot_index       = SlotFieldW'(slot_q);
          res_d.occurrence_count = CountW'(1);
          res_d.is_new_word      = 1'b1;
          res_d.table_full       = 1'b0;
          state_d                = S_OUT;
        end else begin
          wr_idx_d  = idx_q;
          idx_d     = idx_q + 1'b1;
          rd_pend_d = 1'b1;
        end
      end
      S_OUT: begin
        res_d = res_q;
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          out_last_d  = last_q;
          plen_d      = '0;
          trunc_d     = 1'b0;
          if (last_q) begin
            used_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      delim_q     <= DelimReset;
      used_q      <= '0;
      plen_q      <= '0;
      trunc_q     <= 1'b0;
      last_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      plen_q      <= plen_d;
      trunc_q     <= trunc_d;
      last_q      <= last_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    base_q     <= base_d;
    idx_q      <= idx_d;
    wr_idx_q   <= wr_idx_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### design/wfc_checker.sv
// port-level checks on the result stream of the word frequency counter
// depends on wfc_pkg and assert_macros.svh, bound to word_frequency_counter_unit
`default_nettype none
`include "assert_macros.svh"

module wfc_checker
  import wfc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tlast
);

  wfc_result_t res;

  assign res = m_axis_tdata;

  // a stalled word keeps its payload
  `WFC_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // a freshly inserted word always starts at count one
  `WFC_ASSERT_IMP(a_new_one, clk_i, rst_ni, m_axis_tvalid && res.is_new_word, !res.table_full && (res.occurrence_count == 8'd1), "new word with bad count")

  // a word refused for lack of room reports no entry
  `WFC_ASSERT_IMP(a_full_zero, clk_i, rst_ni, m_axis_tvalid && res.table_full, (res.occurrence_count == '0) && (res.slot_index == '0) && !res.is_new_word, "full result not cleared")

  // any stored word has been seen at least once
  `WFC_ASSERT_IMP(a_count_nz, clk_i, rst_ni, m_axis_tvalid && !res.table_full, res.occurrence_count != '0, "stored word with zero count")

endmodule

bind word_frequency_counter_unit wfc_checker u_wfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
